/* rtl/ia32_pkg.sv */
`default_nettype none
package ia32_pkg;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_DIV = 5'd2, OP_MUL = 5'd3, OP_MOV = 5'd4,
    OP_XOR = 5'd5, OP_AND = 5'd6, OP_OR = 5'd7, OP_NOT = 5'd8, OP_LNOT = 5'd9,
    OP_LOR = 5'd10, OP_LAND = 5'd11, OP_EQ = 5'd12, OP_NE = 5'd13, OP_GT = 5'd14,
    OP_LT = 5'd15, OP_GE = 5'd16, OP_LE = 5'd17, OP_INC = 5'd18, OP_DEC = 5'd19,
    OP_SAR = 5'd20, OP_SHL = 5'd21
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_BADOP = 2'd2
  } status_t;

  localparam int unsigned DataW = 32;
  localparam int unsigned DivSteps = DataW;

  // One word in flight: the finished result for every operation but divide,
  // and the working registers of the restoring divider.
  typedef struct packed {
    logic [4:0]       cmd;
    logic [DataW-1:0] res;
    logic [1:0]       st;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] dvs;
    logic             neg;
  } pl_t;

endpackage
`default_nettype wire

/* rtl/ia32_prep.sv */
`default_nettype none
module ia32_prep (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [4:0]       cmd_i,
  input  wire logic [31:0]      a_i,
  input  wire logic [31:0]      b_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output ia32_pkg::pl_t         data_o
);

  logic          v_r;
  ia32_pkg::pl_t d_r;
  ia32_pkg::pl_t d_nxt;
  logic          lt_ab;
  logic          lt_ba;
  logic          big_b;
  logic [31:0]   prod;

  assign lt_ab = $signed(a_i) < $signed(b_i);
  assign lt_ba = $signed(b_i) < $signed(a_i);
  assign big_b = |b_i[31:5];
  assign prod  = a_i * b_i;

  always_comb begin
    d_nxt     = '0;
    d_nxt.cmd = cmd_i;
    d_nxt.st  = ia32_pkg::ST_OK;
    d_nxt.quo = a_i[31] ? (32'd0 - a_i) : a_i;
    d_nxt.dvs = b_i[31] ? (32'd0 - b_i) : b_i;
    d_nxt.neg = a_i[31] ^ b_i[31];
    unique case (cmd_i)
      ia32_pkg::OP_ADD:  d_nxt.res = a_i + b_i;
      ia32_pkg::OP_SUB:  d_nxt.res = a_i - b_i;
      ia32_pkg::OP_DIV:  d_nxt.st  = (b_i == 32'd0) ? ia32_pkg::ST_DIV0 : ia32_pkg::ST_OK;
      ia32_pkg::OP_MUL:  d_nxt.res = prod;
      ia32_pkg::OP_MOV:  d_nxt.res = a_i;
      ia32_pkg::OP_XOR:  d_nxt.res = a_i ^ b_i;
      ia32_pkg::OP_AND:  d_nxt.res = a_i & b_i;
      ia32_pkg::OP_OR:   d_nxt.res = a_i | b_i;
      ia32_pkg::OP_NOT:  d_nxt.res = ~a_i;
      ia32_pkg::OP_LNOT: d_nxt.res = {31'd0, a_i == 32'd0};
      ia32_pkg::OP_LOR:  d_nxt.res = {31'd0, (a_i != 32'd0) || (b_i != 32'd0)};
      ia32_pkg::OP_LAND: d_nxt.res = {31'd0, (a_i != 32'd0) && (b_i != 32'd0)};
      ia32_pkg::OP_EQ:   d_nxt.res = {31'd0, a_i == b_i};
      ia32_pkg::OP_NE:   d_nxt.res = {31'd0, a_i != b_i};
      ia32_pkg::OP_GT:   d_nxt.res = {31'd0, lt_ba};
      ia32_pkg::OP_LT:   d_nxt.res = {31'd0, lt_ab};
      ia32_pkg::OP_GE:   d_nxt.res = {31'd0, !lt_ab};
      ia32_pkg::OP_LE:   d_nxt.res = {31'd0, !lt_ba};
      ia32_pkg::OP_INC:  d_nxt.res = a_i + 32'd1;
      ia32_pkg::OP_DEC:  d_nxt.res = a_i - 32'd1;
      ia32_pkg::OP_SAR:  d_nxt.res = big_b ? {32{a_i[31]}} : 32'($signed(a_i) >>> b_i[4:0]);
      ia32_pkg::OP_SHL:  d_nxt.res = big_b ? 32'd0 : (a_i << b_i[4:0]);
      default:           d_nxt.st  = ia32_pkg::ST_BADOP;
    endcase
  end

  assign ready_o = !v_r || ready_i;
  assign valid_o = v_r;
  assign data_o  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      d_r <= d_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/ia32_div_stage.sv */
`default_nettype none
module ia32_div_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire ia32_pkg::pl_t data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output ia32_pkg::pl_t      data_o
);

  logic          v_r;
  ia32_pkg::pl_t d_r;
  ia32_pkg::pl_t d_nxt;
  logic [32:0]   trial;
  logic [32:0]   diff;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  assign trial = {data_i.rem, data_i.quo[31]};
  assign diff  = trial - {1'b0, data_i.dvs};

  always_comb begin
    d_nxt = data_i;
    if (!diff[32]) begin
      d_nxt.rem = diff[31:0];
    end else begin
      d_nxt.rem = trial[31:0];
    end
    d_nxt.quo = {data_i.quo[30:0], !diff[32]};
  end

  assign ready_o = !v_r || ready_i;
  assign valid_o = v_r;
  assign data_o  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      d_r <= d_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/interpreter_alu_32.sv */
`default_nettype none
// Signed 32-bit ALU. Each input word carries an opcode and two operands and
// gives exactly one result word with a 32-bit value and a status (0 ok, 1
// divide by zero, 2 unknown opcode). The block takes one word per clock
// when nothing stalls. Each word passes one operand stage, 32 restoring
// divide stages of one quotient bit each, and the output register. Every
// operation travels the full pipeline so results leave in order.
// Each stage holds its word while the next stage is full and stalled,
// so back-pressure on the output fills the pipeline bubble by bubble and no
// word is lost or repeated.
// Add, subtract and multiply wrap; shift amounts outside 0 to 31 act as 32.
module interpreter_alu_32 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // Fields from bit 0: cmd[4:0], operand_a[36:5], operand_b[68:37], zero fill.
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // Fields from bit 0: result_value[31:0], status[33:32], zero fill.
  output logic [39:0]      out_tdata
);

  localparam int unsigned N = ia32_pkg::DivSteps;

  logic          v   [N+1];
  logic          rdy [N+1];
  ia32_pkg::pl_t d   [N+1];

  logic          ov_r;
  logic [31:0]   val_r;
  logic [31:0]   val_nxt;
  logic [1:0]    st_r;
  logic          out_ready;

  ia32_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_tvalid),
    .ready_o (in_tready),
    .cmd_i   (in_tdata[4:0]),
    .a_i     (in_tdata[36:5]),
    .b_i     (in_tdata[68:37]),
    .valid_o (v[0]),
    .ready_i (rdy[0]),
    .data_o  (d[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_div
    ia32_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (v[i]),
      .ready_o (rdy[i]),
      .data_i  (d[i]),
      .valid_o (v[i+1]),
      .ready_i (rdy[i+1]),
      .data_o  (d[i+1])
    );
  end

  // Output register: applies the quotient sign and picks the divide result.
  assign out_ready = !ov_r || out_tready;
  assign rdy[N]    = out_ready;

  always_comb begin
    val_nxt = d[N].res;
    if (d[N].cmd == ia32_pkg::OP_DIV && d[N].st == ia32_pkg::ST_OK) begin
      val_nxt = d[N].neg ? (32'd0 - d[N].quo) : d[N].quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_ready) begin
      ov_r <= v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && v[N]) begin
      val_r <= val_nxt;
      st_r  <= d[N].st;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, st_r, val_r};

  // An error status always comes with a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[33:32] != ia32_pkg::ST_OK) |-> (out_tdata[31:0] == 32'd0))
    else $error("error status with non-zero value");

  // Status code three is never produced.
  a_st_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[33:32] != 2'd3))
    else $error("status out of range");

  // A stalled output word is held until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("output word changed while stalled");

endmodule
`default_nettype wire

/* bench/interpreter_alu_32_tb.sv */
`default_nettype none
module interpreter_alu_32_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Bits of the input word that the block reads: cmd, operand_a and operand_b.
  typedef struct packed {
    logic [31:0] b;
    logic [31:0] a;
    logic [4:0]  cmd;
  } alu_req_t;

  typedef struct packed {
    logic [31:0]       value;
    ia32_pkg::status_t st;
  } alu_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  interpreter_alu_32 uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  alu_res_t    pending_results[$];
  int          mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_output = 1'b0;
  longint      cycle_count = 0;

  // The predictor: one result per word, nothing kept between words.
  function automatic alu_res_t alu_predict(alu_req_t rq);
    alu_res_t    r;
    logic [31:0] ma, mb, q;
    r.value = '0;
    r.st = ia32_pkg::ST_OK;
    case (rq.cmd)
      ia32_pkg::OP_ADD:  r.value = rq.a + rq.b;
      ia32_pkg::OP_SUB:  r.value = rq.a - rq.b;
      ia32_pkg::OP_DIV: begin
        if (rq.b == 0) begin
          r.st = ia32_pkg::ST_DIV0;
        end else begin
          // Magnitudes taken unsigned, so the most negative value divided by
          // minus one wraps back onto itself.
          ma = rq.a[31] ? -rq.a : rq.a;
          mb = rq.b[31] ? -rq.b : rq.b;
          q = ma / mb;
          r.value = (rq.a[31] ^ rq.b[31]) ? -q : q;
        end
      end
      ia32_pkg::OP_MUL:  r.value = rq.a * rq.b;
      ia32_pkg::OP_MOV:  r.value = rq.a;
      ia32_pkg::OP_XOR:  r.value = rq.a ^ rq.b;
      ia32_pkg::OP_AND:  r.value = rq.a & rq.b;
      ia32_pkg::OP_OR:   r.value = rq.a | rq.b;
      ia32_pkg::OP_NOT:  r.value = ~rq.a;
      ia32_pkg::OP_LNOT: r.value = {31'd0, rq.a == 0};
      ia32_pkg::OP_LOR:  r.value = {31'd0, (rq.a != 0) || (rq.b != 0)};
      ia32_pkg::OP_LAND: r.value = {31'd0, (rq.a != 0) && (rq.b != 0)};
      ia32_pkg::OP_EQ:   r.value = {31'd0, rq.a == rq.b};
      ia32_pkg::OP_NE:   r.value = {31'd0, rq.a != rq.b};
      ia32_pkg::OP_GT:   r.value = {31'd0, $signed(rq.a) > $signed(rq.b)};
      ia32_pkg::OP_LT:   r.value = {31'd0, $signed(rq.a) < $signed(rq.b)};
      ia32_pkg::OP_GE:   r.value = {31'd0, $signed(rq.a) >= $signed(rq.b)};
      ia32_pkg::OP_LE:   r.value = {31'd0, $signed(rq.a) <= $signed(rq.b)};
      ia32_pkg::OP_INC:  r.value = rq.a + 1;
      ia32_pkg::OP_DEC:  r.value = rq.a - 1;
      // An out-of-range amount, negative ones included, behaves as 32.
      ia32_pkg::OP_SAR:
        r.value = (rq.b > 31) ? {32{rq.a[31]}} : 32'($signed(rq.a) >>> rq.b[4:0]);
      ia32_pkg::OP_SHL:  r.value = (rq.b > 31) ? 32'd0 : rq.a << rq.b[4:0];
      default: r.st = ia32_pkg::ST_BADOP;
    endcase
    return r;
  endfunction

  // Offers one word, with a random gap first, and returns once it is taken.
  // Valid stays high from one word to the next when there is no gap.
  task automatic send_word(logic [4:0] cmd, logic [31:0] a, logic [31:0] b);
    alu_req_t rq;
    rq = '{b: b, a: a, cmd: cmd};
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= {3'd0, rq};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(alu_predict(rq));
  endtask

  // Receiver: stalls at random unless a long hold-off is in progress.
  always @(posedge clk) begin
    if (rst_n) out_tready <= !hold_output && ($urandom_range(99) >= recv_idle_pct);
  end

  // Each accepted result is matched with the oldest prediction.
  always @(posedge clk) begin
    alu_res_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[31:0] !== exp_r.value || out_tdata[33:32] !== exp_r.st ||
            out_tdata[39:34] !== 6'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %h status %0d, got value %h status %0d",
                     exp_r.value, exp_r.st, out_tdata[31:0], out_tdata[33:32]);
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(2) - 1;
      1: return $urandom_range(3) - 1;
      2: return $urandom_range(40) - 4;
      3: return -$urandom_range(40);
      default: return $urandom;
    endcase
  endfunction

  // Extremes of the operands for every opcode, illegal ones included.
  task automatic test_directed_edges();
    logic [31:0] vals[5];
    vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1};
    for (int op = 0; op < 32; op++) begin
      send_word(op[4:0], vals[op % 5], vals[(op / 5) % 5]);
    end
  endtask

  // Divide overflow, divide by zero, a negative dividend, shifts at and past their range, and a multiply that wraps.
  task automatic test_special_cases();
    send_word(ia32_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(ia32_pkg::OP_DIV, 32'd7, 32'd0);
    send_word(ia32_pkg::OP_DIV, -32'sd7, 32'd2);
    send_word(ia32_pkg::OP_SAR, 32'h8000_0001, 32'd32);
    send_word(ia32_pkg::OP_SAR, 32'h8000_0001, 32'hFFFF_FFFF);
    send_word(ia32_pkg::OP_SAR, 32'h4000_0001, 32'd31);
    send_word(ia32_pkg::OP_SHL, 32'hFFFF_FFFF, 32'd31);
    send_word(ia32_pkg::OP_SHL, 32'hFFFF_FFFF, 32'h8000_0000);
    send_word(ia32_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
  endtask

  task automatic test_random_words(int count);
    logic [4:0] cmd;
    for (int i = 0; i < count; i++) begin
      // Illegal opcodes only now and then, so the legal ones get most of the run.
      cmd = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 22)) : 5'($urandom_range(21));
      send_word(cmd, rand_operand(), rand_operand());
    end
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall
  // the input, while words keep being offered.
  task automatic test_output_backpressure();
    hold_output = 1'b1;
    fork
      begin
        test_random_words(60);
        in_tvalid <= 1'b0;
      end
      begin
        repeat (150) @(posedge clk);
        hold_output = 1'b0;
      end
    join
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 31;
    recv_idle_pct = 65;
    test_directed_edges();
    test_special_cases();
    test_random_words(400);
    send_idle_pct = 65;
    recv_idle_pct = 31;
    test_random_words(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_random_words(400);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
